### sv/tpg_pkg.sv
// Package for the trapezoidal profile generator.
// Holds field widths, codes, the sequencer state type and shared defaults.
// No dependencies.
package tpg_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_W     = 25;  // acceleration and speed limits
    localparam int POS_W     = 32;  // positions, velocities, times
    localparam int DT_W      = 16;  // step_time
    localparam int ACC_OUT_W = 26;  // signed acceleration
    localparam int MC_W      = 33;  // serial multiplier: signed multiplicand
    localparam int MP_W      = 25;  // serial multiplier: unsigned multiplier
    localparam int SQ_W      = 50;  // width of the speed limit squared

    localparam logic [CFG_W-1:0] CFG_RESET = 25'd65536;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic REG_MAX_ACCEL = 1'b0;
    localparam logic REG_MAX_VEL   = 1'b1;

    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_TR,
        ST_RAMP,
        ST_CRU,
        ST_Y,
        ST_ROOT,
        ST_PLAN,
        ST_ACC,
        ST_POS,
        ST_OUT
    } tpg_state_t;

endpackage

### sv/trapezoidal_profile_generator_unit.sv
// Trapezoidal profile generator, one axis, signed fixed point.
// A tick runs two serial multiplies, velocity then position; once past the stop time it goes
// straight to the result. A start squares the speed limit and runs three divides, or for a short
// segment two divides and a square root; when start equals goal it goes straight to the result.
// The sequencer holds one item at a time; in_ready rises in the same cycle the result turns valid.
// Reset clears the profile state and sets both limits to 1.0. Needs tpg_pkg, tpg_mul, tpg_divsqrt.
module trapezoidal_profile_generator_unit #(
    parameter int FRAC_BITS = tpg_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [tpg_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic signed [tpg_pkg::POS_W-1:0]    start_position,
    input  logic signed [tpg_pkg::POS_W-1:0]    goal_position,
    input  logic [tpg_pkg::DT_W-1:0]            step_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                active,
    output logic [1:0]                          phase,
    output logic signed [tpg_pkg::ACC_OUT_W-1:0] accel_out,
    output logic signed [tpg_pkg::POS_W-1:0]    velocity_out,
    output logic signed [tpg_pkg::POS_W-1:0]    position_out,
    output logic [tpg_pkg::POS_W-1:0]           time_out
);
    import tpg_pkg::*;

    localparam int NUM_W = (32 + 2 * FRAC_BITS > SQ_W) ? 32 + 2 * FRAC_BITS : SQ_W;
    localparam int RT_W  = NUM_W / 2;
    localparam int MUL_W = MC_W + MP_W;

    function automatic logic signed [POS_W-1:0] sat_s32(input logic signed [MUL_W:0] x);
        logic signed [MUL_W:0] hi;
        logic signed [MUL_W:0] lo;
        hi = (MUL_W+1)'(32'sh7FFFFFFF);
        lo = (MUL_W+1)'(32'sh80000000);
        if (x > hi)
            sat_s32 = 32'sh7FFFFFFF;
        else if (x < lo)
            sat_s32 = 32'sh80000000;
        else
            sat_s32 = x[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_q(input logic [NUM_W-1:0] q);
        sat_q = (|q[NUM_W-1:POS_W]) ? '1 : q[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] x,
                                                 input logic [POS_W-1:0] y);
        logic [POS_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        sat_add = s[POS_W] ? '1 : s[POS_W-1:0];
    endfunction

    tpg_state_t state_reg, state_next;

    logic [CFG_W-1:0]            max_accel_reg, max_accel_next;
    logic [CFG_W-1:0]            max_vel_reg, max_vel_next;
    logic [POS_W-1:0]            elapsed_reg, elapsed_next;
    logic [POS_W-1:0]            cruise_t_reg, cruise_t_next;
    logic [POS_W-1:0]            decel_t_reg, decel_t_next;
    logic [POS_W-1:0]            stop_t_reg, stop_t_next;
    logic signed [ACC_OUT_W-1:0] init_acc_reg, init_acc_next;
    logic signed [ACC_OUT_W-1:0] cur_acc_reg, cur_acc_next;
    logic signed [POS_W-1:0]     vel_reg, vel_next;
    logic signed [POS_W-1:0]     pos_reg, pos_next;
    logic                        out_valid_reg, out_valid_next;

    logic [POS_W-1:0]            dist_reg, dist_next;
    logic [POS_W-1:0]            tr_reg, tr_next;
    logic [POS_W-1:0]            ramp_reg, ramp_next;
    logic [POS_W-1:0]            cru_len_reg, cru_len_next;
    logic [DT_W-1:0]             dt_reg, dt_next;
    logic                        res_active_reg, res_active_next;
    logic [1:0]                  res_phase_reg, res_phase_next;
    logic                        res_start_reg, res_start_next;
    logic                        o_active_reg, o_active_next;
    logic [1:0]                  o_phase_reg, o_phase_next;
    logic signed [ACC_OUT_W-1:0] o_acc_reg, o_acc_next;
    logic signed [POS_W-1:0]     o_vel_reg, o_vel_next;
    logic signed [POS_W-1:0]     o_pos_reg, o_pos_next;
    logic [POS_W-1:0]            o_time_reg, o_time_next;

    logic                        in_fire, out_free;
    logic [CFG_W-1:0]            a_eff, v_eff;
    logic signed [ACC_OUT_W-1:0] acc_pos;
    logic signed [POS_W-1:0]     vel_pos;
    logic signed [POS_W:0]       diff_gs, neg_gs;
    logic                        dir_up;
    logic [POS_W-1:0]            d_abs;
    logic [POS_W:0]              el_sum;
    logic [POS_W-1:0]            el_new;
    logic                        past_stop, in_decel, in_cruise;
    logic signed [ACC_OUT_W-1:0] accel_sel;
    logic signed [POS_W-1:0]     vel_sel;
    logic [1:0]                  phase_sel;

    logic                        mul_start, mul_done;
    logic signed [MC_W-1:0]      mul_mc;
    logic [MP_W-1:0]             mul_mp;
    logic signed [MUL_W-1:0]     mul_prod, prod_sh;
    logic signed [POS_W-1:0]     vel_upd, pos_upd;

    logic                        ds_start, ds_sqrt, ds_done;
    logic [NUM_W-1:0]            ds_num, ds_quo;
    logic [CFG_W-1:0]            ds_den;
    logic [RT_W-1:0]             ds_root;
    logic                        tr_lt_d;
    logic [POS_W-1:0]            decel_calc;

    tpg_mul #(
        .MC_W (MC_W),
        .MP_W (MP_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .mc    (mul_mc),
        .mp    (mul_mp),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tpg_divsqrt #(
        .NUM_W (NUM_W),
        .DEN_W (CFG_W)
    ) u_divsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ds_start),
        .sqrt_mode (ds_sqrt),
        .num       (ds_num),
        .den       (ds_den),
        .done      (ds_done),
        .quo       (ds_quo),
        .root      (ds_root)
    );

    // shared datapath terms
    always_comb
    begin
        in_fire   = in_valid && in_ready;
        out_free  = !out_valid_reg || out_ready;
        a_eff     = (max_accel_reg == '0) ? CFG_W'(1) : max_accel_reg;
        v_eff     = (max_vel_reg == '0) ? CFG_W'(1) : max_vel_reg;
        acc_pos   = $signed(ACC_OUT_W'(a_eff));
        vel_pos   = $signed(POS_W'(v_eff));
        diff_gs   = (POS_W+1)'(goal_position) - (POS_W+1)'(start_position);
        neg_gs    = -diff_gs;
        dir_up    = goal_position > start_position;
        d_abs     = dir_up ? diff_gs[POS_W-1:0] : neg_gs[POS_W-1:0];
        el_sum    = (POS_W+1)'(elapsed_reg) + (POS_W+1)'(step_time);
        el_new    = el_sum[POS_W] ? '1 : el_sum[POS_W-1:0];
        past_stop = el_new > stop_t_reg;
        in_decel  = el_new > decel_t_reg;
        in_cruise = el_new > cruise_t_reg;
        if (in_decel)
        begin
            accel_sel = -init_acc_reg;
            vel_sel   = vel_reg;
            phase_sel = PH_DECEL;
        end
        else if (in_cruise)
        begin
            accel_sel = '0;
            vel_sel   = (init_acc_reg > 0) ? vel_pos : -vel_pos;
            phase_sel = PH_CRUISE;
        end
        else
        begin
            accel_sel = cur_acc_reg;
            vel_sel   = vel_reg;
            phase_sel = PH_ACCEL;
        end
        prod_sh    = mul_prod >>> FRAC_BITS;
        vel_upd    = sat_s32((MUL_W+1)'(vel_reg) + {prod_sh[MUL_W-1], prod_sh});
        pos_upd    = sat_s32((MUL_W+1)'(pos_reg) + {prod_sh[MUL_W-1], prod_sh});
        tr_lt_d    = ds_quo < NUM_W'(dist_reg);
        decel_calc = sat_add(ramp_reg, cru_len_reg);
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == CMD_START)
                        state_next = (d_abs == '0) ? ST_OUT : ST_SQ;
                    else
                        state_next = past_stop ? ST_OUT : ST_ACC;
                end
            end
            ST_SQ:   if (mul_done) state_next = ST_TR;
            ST_TR:   if (ds_done) state_next = tr_lt_d ? ST_RAMP : ST_Y;
            ST_RAMP: if (ds_done) state_next = ST_CRU;
            ST_CRU:  if (ds_done) state_next = ST_PLAN;
            ST_Y:    if (ds_done) state_next = ST_ROOT;
            ST_ROOT: if (ds_done) state_next = ST_PLAN;
            ST_PLAN: state_next = ST_OUT;
            ST_ACC:  if (mul_done) state_next = ST_POS;
            ST_POS:  if (mul_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: unit launches and operands
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        mul_start = 1'b0;
        mul_mc    = '0;
        mul_mp    = '0;
        ds_start  = 1'b0;
        ds_sqrt   = 1'b0;
        ds_num    = '0;
        ds_den    = a_eff;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && command == CMD_START && d_abs != '0)
                begin
                    mul_start = 1'b1;
                    mul_mc    = $signed(MC_W'(v_eff));
                    mul_mp    = MP_W'(v_eff);
                end
                else if (in_fire && command == CMD_TICK && !past_stop)
                begin
                    mul_start = 1'b1;
                    mul_mc    = MC_W'(accel_sel);
                    mul_mp    = MP_W'(step_time);
                end
            end
            ST_SQ:
            begin
                ds_start = mul_done;
                ds_num   = NUM_W'(mul_prod[SQ_W-1:0]);
            end
            ST_TR:
            begin
                ds_start = ds_done;
                if (tr_lt_d)
                    ds_num = NUM_W'(v_eff) << FRAC_BITS;
                else
                    ds_num = NUM_W'(dist_reg) << (2 * FRAC_BITS);
            end
            ST_RAMP:
            begin
                ds_start = ds_done;
                ds_num   = NUM_W'(dist_reg - tr_reg) << FRAC_BITS;
                ds_den   = v_eff;
            end
            ST_Y:
            begin
                ds_start = ds_done;
                ds_sqrt  = 1'b1;
                ds_num   = ds_quo;
            end
            ST_ACC:
            begin
                mul_start = mul_done;
                mul_mc    = MC_W'(vel_upd);
                mul_mp    = MP_W'(dt_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        max_accel_next  = max_accel_reg;
        max_vel_next    = max_vel_reg;
        elapsed_next    = elapsed_reg;
        cruise_t_next   = cruise_t_reg;
        decel_t_next    = decel_t_reg;
        stop_t_next     = stop_t_reg;
        init_acc_next   = init_acc_reg;
        cur_acc_next    = cur_acc_reg;
        vel_next        = vel_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        dist_next       = dist_reg;
        tr_next         = tr_reg;
        ramp_next       = ramp_reg;
        cru_len_next    = cru_len_reg;
        dt_next         = dt_reg;
        res_active_next = res_active_reg;
        res_phase_next  = res_phase_reg;
        res_start_next  = res_start_reg;
        o_active_next   = o_active_reg;
        o_phase_next    = o_phase_reg;
        o_acc_next      = o_acc_reg;
        o_vel_next      = o_vel_reg;
        o_pos_next      = o_pos_reg;
        o_time_next     = o_time_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_ACCEL: max_accel_next = cfg_data;
                REG_MAX_VEL:   max_vel_next   = cfg_data;
                default:       max_vel_next   = max_vel_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && command == CMD_START)
                begin
                    elapsed_next   = '0;
                    vel_next       = '0;
                    pos_next       = start_position;
                    dist_next      = d_abs;
                    res_start_next = 1'b1;
                    if (d_abs == '0)
                    begin
                        cruise_t_next   = '0;
                        decel_t_next    = '0;
                        stop_t_next     = '0;
                        init_acc_next   = '0;
                        cur_acc_next    = '0;
                        res_active_next = 1'b0;
                        res_phase_next  = PH_DONE;
                    end
                    else
                    begin
                        init_acc_next   = dir_up ? acc_pos : -acc_pos;
                        cur_acc_next    = dir_up ? acc_pos : -acc_pos;
                        res_active_next = 1'b1;
                        res_phase_next  = PH_ACCEL;
                    end
                end
                else if (in_fire)
                begin
                    elapsed_next   = el_new;
                    dt_next        = step_time;
                    res_start_next = 1'b0;
                    if (past_stop)
                    begin
                        res_active_next = 1'b0;
                        res_phase_next  = PH_DONE;
                    end
                    else
                    begin
                        res_active_next = 1'b1;
                        res_phase_next  = phase_sel;
                        cur_acc_next    = accel_sel;
                        vel_next        = vel_sel;
                    end
                end
            end
            ST_TR:   if (ds_done) tr_next = ds_quo[POS_W-1:0];
            ST_RAMP: if (ds_done) ramp_next = sat_q(ds_quo);
            ST_CRU:  if (ds_done) cru_len_next = sat_q(ds_quo);
            ST_ROOT:
            begin
                if (ds_done)
                begin
                    ramp_next    = sat_q(NUM_W'(ds_root));
                    cru_len_next = '0;
                end
            end
            ST_PLAN:
            begin
                cruise_t_next = ramp_reg;
                decel_t_next  = decel_calc;
                stop_t_next   = sat_add(decel_calc, ramp_reg);
            end
            ST_ACC:  if (mul_done) vel_next = vel_upd;
            ST_POS:  if (mul_done) pos_next = pos_upd;
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_active_next  = res_active_reg;
                    o_phase_next   = res_phase_reg;
                    o_acc_next     = res_active_reg ? cur_acc_reg : '0;
                    o_vel_next     = vel_reg;
                    o_pos_next     = pos_reg;
                    o_time_next    = res_start_reg ? stop_t_reg : elapsed_reg;
                end
            end
            default:
            begin
                dt_next = dt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_accel_reg <= CFG_RESET;
            max_vel_reg   <= CFG_RESET;
            elapsed_reg   <= '0;
            cruise_t_reg  <= '0;
            decel_t_reg   <= '0;
            stop_t_reg    <= '0;
            init_acc_reg  <= '0;
            cur_acc_reg   <= '0;
            vel_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_accel_reg <= max_accel_next;
            max_vel_reg   <= max_vel_next;
            elapsed_reg   <= elapsed_next;
            cruise_t_reg  <= cruise_t_next;
            decel_t_reg   <= decel_t_next;
            stop_t_reg    <= stop_t_next;
            init_acc_reg  <= init_acc_next;
            cur_acc_reg   <= cur_acc_next;
            vel_reg       <= vel_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg       <= dist_next;
        tr_reg         <= tr_next;
        ramp_reg       <= ramp_next;
        cru_len_reg    <= cru_len_next;
        dt_reg         <= dt_next;
        res_active_reg <= res_active_next;
        res_phase_reg  <= res_phase_next;
        res_start_reg  <= res_start_next;
        o_active_reg   <= o_active_next;
        o_phase_reg    <= o_phase_next;
        o_acc_reg      <= o_acc_next;
        o_vel_reg      <= o_vel_next;
        o_pos_reg      <= o_pos_next;
        o_time_reg     <= o_time_next;
    end

    assign out_valid    = out_valid_reg;
    assign active       = o_active_reg;
    assign phase        = o_phase_reg;
    assign accel_out    = o_acc_reg;
    assign velocity_out = o_vel_reg;
    assign position_out = o_pos_reg;
    assign time_out     = o_time_reg;

    a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("item accepted but sequencer stayed idle");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_SQ || state_reg == ST_ACC || state_reg == ST_POS))
        else $error("multiplier finished outside a multiply step");

    a_ds_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        ds_done |-> (state_reg == ST_TR || state_reg == ST_RAMP || state_reg == ST_CRU
                     || state_reg == ST_Y || state_reg == ST_ROOT))
        else $error("divider finished outside a divide step");

    a_plan_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PLAN |=> (stop_t_reg >= decel_t_reg && decel_t_reg >= cruise_t_reg))
        else $error("planned times out of order");

endmodule

### sv/tpg_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand by unsigned multiplier.
// One multiplier bit per cycle. Depends on tpg_pkg.
module tpg_mul #(
    parameter int MC_W = tpg_pkg::MC_W,
    parameter int MP_W = tpg_pkg::MP_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [MC_W-1:0]        mc,
    input  logic [MP_W-1:0]               mp,
    output logic                          done,
    output logic signed [MC_W+MP_W-1:0]   prod
);
    localparam int CNT_W = $clog2(MP_W + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [MC_W-1:0] mc_reg, mc_next;
    logic signed [MC_W:0]   hi_reg, hi_next;
    logic [MP_W-1:0]        lo_reg, lo_next;
    logic signed [MC_W:0]   sum;

    always_comb
    begin
        sum = hi_reg + (lo_reg[0] ? {mc_reg[MC_W-1], mc_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mc_next   = mc_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MP_W);
            mc_next   = mc;
            hi_next   = '0;
            lo_next   = mp;
        end
        else if (busy_reg)
        begin
            hi_next  = {sum[MC_W], sum[MC_W:1]};
            lo_next  = {sum[0], lo_reg[MP_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg <= mc_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg[MC_W-1:0], lo_reg};

endmodule

### sv/tpg_divsqrt.sv
// Serial unsigned divider (one quotient bit per cycle) and integer square
// root (one root bit per cycle, two radicand bits consumed). Depends on tpg_pkg.
module tpg_divsqrt #(
    parameter int NUM_W = 64,
    parameter int DEN_W = tpg_pkg::CFG_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 sqrt_mode,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic                 done,
    output logic [NUM_W-1:0]     quo,
    output logic [NUM_W/2-1:0]   root
);
    localparam int RT_W  = NUM_W / 2;
    localparam int SR_W  = RT_W + 2;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               mode_reg, mode_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   sh_reg, sh_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [SR_W-1:0]    srem_reg, srem_next;
    logic [RT_W-1:0]    root_reg, root_next;

    logic [DEN_W:0]     div_sh, div_diff;
    logic               div_ge;
    logic [SR_W-1:0]    sq_sh, sq_trial, sq_diff;
    logic               sq_ge;

    always_comb
    begin
        div_sh   = {rem_reg, sh_reg[NUM_W-1]};
        div_diff = div_sh - {1'b0, den_reg};
        div_ge   = div_sh >= {1'b0, den_reg};
        sq_sh    = {srem_reg[SR_W-3:0], sh_reg[NUM_W-1:NUM_W-2]};
        sq_trial = {root_reg, 2'b01};
        sq_diff  = sq_sh - sq_trial;
        sq_ge    = sq_sh >= sq_trial;

        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            mode_next = sqrt_mode;
            cnt_next  = sqrt_mode ? CNT_W'(RT_W) : CNT_W'(NUM_W);
            sh_next   = num;
            den_next  = den;
            rem_next  = '0;
            srem_next = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                srem_next = sq_ge ? sq_diff : sq_sh;
                root_next = {root_reg[RT_W-2:0], sq_ge};
                sh_next   = {sh_reg[NUM_W-3:0], 2'b00};
            end
            else
            begin
                rem_next = div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
                sh_next  = {sh_reg[NUM_W-2:0], div_ge};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg;
    assign root = root_reg;

endmodule

### verif/testbench.sv
// Testbench for trapezoidal_profile_generator_unit: a table of directed items, then random
// segments under several limit settings, each result checked against a local profile model or a table entry.
// Depends on tpg_pkg and the RTL of the block.
module testbench;
    import tpg_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int WATCH_LIMIT = 20000;
    localparam longint unsigned U32_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic                        active;
        logic [1:0]                  phase;
        logic signed [ACC_OUT_W-1:0] accel;
        logic signed [POS_W-1:0]     velocity;
        logic signed [POS_W-1:0]     position;
        logic [POS_W-1:0]            elapsed;
    } profile_t;

    typedef struct {
        logic                    cmd;
        logic signed [POS_W-1:0] start_pos;
        logic signed [POS_W-1:0] goal_pos;
        logic [DT_W-1:0]         dt;
        bit                      known;
        profile_t                res;
    } row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic                        cfg_addr = REG_MAX_ACCEL;
    logic [CFG_W-1:0]            cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        command = CMD_START;
    logic signed [POS_W-1:0]     start_position = '0;
    logic signed [POS_W-1:0]     goal_position = '0;
    logic [DT_W-1:0]             step_time = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        active;
    logic [1:0]                  phase;
    logic signed [ACC_OUT_W-1:0] accel_out;
    logic signed [POS_W-1:0]     velocity_out;
    logic signed [POS_W-1:0]     position_out;
    logic [POS_W-1:0]            time_out;

    trapezoidal_profile_generator_unit dut (.*);

    always #1 clk = ~clk;

    // profile model state
    longint unsigned accel_lim = CFG_RESET, vel_lim = CFG_RESET;
    longint unsigned t_elapsed, t_cruise, t_decel, t_stop;
    longint          a_init, a_cur, v_cur, p_cur;

    profile_t   profile_q[$];
    int         errors = 0;
    bit         calm = 0;
    bit         hold_req = 0;
    int         hold_cnt = 0;
    int         idle_cnt = 0;

    function automatic longint unsigned sat_u32(longint unsigned x);
        return x > U32_MAX ? U32_MAX : x;
    endfunction

    function automatic longint sat_s32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic void plan_times(longint unsigned d, longint unsigned a,
                                       longint unsigned v);
        longint unsigned ramp_dist, ramp, cruise, num, q1, r1, y, add;
        ramp_dist = (v * v) / a;
        if (ramp_dist < d) begin
            ramp = sat_u32((v << FB) / a);
            cruise = sat_u32(((d - ramp_dist) << FB) / v);
        end else begin
            num = d << FB;
            q1 = num / a;
            r1 = num % a;
            if ((q1 >> (64 - FB)) != 0)
                y = '1;
            else begin
                y = q1 << FB;
                add = (r1 << FB) / a;
                y = (y > ~add) ? '1 : y + add;
            end
            ramp = sat_u32(int_sqrt(y));
            cruise = 0;
        end
        t_cruise = ramp;
        t_decel = sat_u32(ramp + cruise);
        t_stop = sat_u32(t_decel + ramp);
    endfunction

    function automatic profile_t profile_step(logic cmd, logic signed [31:0] sp,
                                              logic signed [31:0] gp, logic [15:0] dt);
        longint unsigned a, v, d;
        longint          s, g;
        profile_t        r;
        a = accel_lim ? accel_lim : 1;
        v = vel_lim ? vel_lim : 1;
        if (cmd == CMD_START) begin
            s = sp;
            g = gp;
            d = g > s ? g - s : s - g;
            t_elapsed = 0;
            v_cur = 0;
            p_cur = s;
            if (d != 0) begin
                plan_times(d, a, v);
                a_init = g > s ? longint'(a) : -longint'(a);
            end else begin
                t_cruise = 0;
                t_decel = 0;
                t_stop = 0;
                a_init = 0;
            end
            a_cur = a_init;
            r.active = d != 0;
            r.phase = d != 0 ? PH_ACCEL : PH_DONE;
            r.accel = ACC_OUT_W'(a_init);
            r.elapsed = POS_W'(t_stop);
        end else begin
            t_elapsed = sat_u32(t_elapsed + dt);
            r.elapsed = POS_W'(t_elapsed);
            if (t_elapsed > t_stop) begin
                r.active = 1'b0;
                r.phase = PH_DONE;
                r.accel = '0;
            end else begin
                if (t_elapsed > t_decel) begin
                    a_cur = -a_init;
                    r.phase = PH_DECEL;
                end else if (t_elapsed > t_cruise) begin
                    a_cur = 0;
                    v_cur = a_init > 0 ? longint'(v) : -longint'(v);
                    r.phase = PH_CRUISE;
                end else
                    r.phase = PH_ACCEL;
                v_cur = sat_s32(v_cur + ((a_cur * longint'(dt)) >>> FB));
                p_cur = sat_s32(p_cur + ((v_cur * longint'(dt)) >>> FB));
                r.active = 1'b1;
                r.accel = ACC_OUT_W'(a_cur);
            end
        end
        r.velocity = POS_W'(v_cur);
        r.position = POS_W'(p_cur);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // result side: random stalls, long hold-off on request
    always @(posedge clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt <= 400;
            out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else
            out_ready <= calm || ($urandom_range(99) >= 38);
    end

    // result checker and watchdog
    always @(posedge clk) begin
        profile_t want;
        if (rst_n && out_valid && out_ready) begin
            if (profile_q.size() == 0) begin
                report_mismatch("result items beyond expected", 1, 0);
            end else begin
                want = profile_q.pop_front();
                if (active !== want.active) report_mismatch("active", active, want.active);
                if (phase !== want.phase) report_mismatch("phase", phase, want.phase);
                if (accel_out !== want.accel) report_mismatch("accel", accel_out, want.accel);
                if (velocity_out !== want.velocity)
                    report_mismatch("velocity", velocity_out, want.velocity);
                if (position_out !== want.position)
                    report_mismatch("position", position_out, want.position);
                if (time_out !== want.elapsed) report_mismatch("time", time_out, want.elapsed);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cnt <= 0;
        else if (idle_cnt >= WATCH_LIMIT) begin
            $display("status: fail");
            $finish;
        end else
            idle_cnt <= idle_cnt + 1;
    end

    task automatic send_item(logic cmd, logic signed [31:0] sp, logic signed [31:0] gp,
                             logic [15:0] dt, bit known, profile_t res);
        int       gap;
        profile_t p;
        gap = 0;
        while (!calm && $urandom_range(99) < 38) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        start_position <= sp;
        goal_position <= gp;
        step_time <= dt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = profile_step(cmd, sp, gp, dt);
        profile_q.push_back(known ? res : p);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (profile_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_limits(logic [CFG_W-1:0] a, logic [CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= REG_MAX_ACCEL;
        cfg_data <= a;
        @(posedge clk);
        cfg_addr <= REG_MAX_VEL;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        accel_lim = a;
        vel_lim = v;
    endtask

    task automatic random_segments(int n);
        logic signed [31:0] sp, gp;
        int                 ticks;
        profile_t           none;
        none = '0;
        repeat (n) begin
            sp = $urandom;
            case ($urandom_range(9))
                0: gp = $urandom;
                1: gp = sp;
                default: gp = sp + $signed($urandom_range(1, 32'h0010_0000))
                               * ($urandom_range(1) ? 1 : -1);
            endcase
            send_item(CMD_START, sp, gp, 16'($urandom), 0, none);
            ticks = $urandom_range(2, 12);
            repeat (ticks) begin
                case ($urandom_range(9))
                    0: send_item(CMD_TICK, $urandom, $urandom, 16'd0, 0, none);
                    1: send_item(CMD_TICK, $urandom, $urandom, 16'($urandom), 0, none);
                    default: send_item(CMD_TICK, $urandom, $urandom,
                                       16'($urandom_range(4096, 65535)), 0, none);
                endcase
            end
        end
    endtask

    row_t dir_rows[] = '{
        '{CMD_TICK, 0, 0, 16'd100, 1, '{1'b0, PH_DONE, 26'sd0, 32'sd0, 32'sd0, 32'd100}},
        '{CMD_START, 32'sd5, 32'sd5, 16'd0, 1,
          '{1'b0, PH_DONE, 26'sd0, 32'sd0, 32'sd5, 32'd0}},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_START, 32'sd0, 32'sd262144, 16'd0, 0, '0},
        '{CMD_TICK, 0, 0, 16'd0, 0, '0},
        '{CMD_TICK, 0, 0, 16'd32768, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_START, 32'sd262144, 32'sd1, 16'd0, 0, '0},
        '{CMD_TICK, 0, 0, 16'd1, 0, '0},
        '{CMD_TICK, 0, 0, 16'd40000, 0, '0},
        '{CMD_START, -32'sd2147483648, 32'sd2147483647, 16'd0, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_START, 32'sd2147483647, -32'sd2147483648, 16'd0, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_START, 32'sd0, 32'sd1, 16'd0, 0, '0},
        '{CMD_TICK, 0, 0, 16'd1, 0, '0},
        '{CMD_TICK, 0, 0, 16'd65535, 0, '0},
        '{CMD_START, -32'sd7, -32'sd7, 16'd0, 1,
          '{1'b0, PH_DONE, 26'sd0, 32'sd0, -32'sd7, 32'd0}}
    };

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].start_pos, dir_rows[i].goal_pos,
                      dir_rows[i].dt, dir_rows[i].known, dir_rows[i].res);
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_limits(25'd1, 25'd16777216);
                1: set_limits(25'd16777216, 25'd1);
                2: set_limits(25'd0, 25'd0);
                3: set_limits(25'd16777216, 25'd16777216);
                default: set_limits(CFG_W'($urandom_range(4096, 1 << 20)),
                                    CFG_W'($urandom_range(4096, 1 << 20)));
            endcase
            calm = (ph == 5);
            if (ph == 6) hold_req = 1;
            random_segments(ph < 4 ? 4 : 8);
            drain();
        end
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
